[sv/greedy_point_clustering_core_macros.svh]
// Assertion macros shared by the clustering core.
`ifndef GREEDY_POINT_CLUSTERING_CORE_MACROS_SVH
`define GREEDY_POINT_CLUSTERING_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpc assertion failed");

// Next-cycle implication, disabled while reset is low.
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpc assertion failed");

`endif

[sv/gpc_pkg.sv]
// Shared constants and types for the greedy point clustering core.
package gpc_pkg;

  localparam int COORD_W        = 16;
  localparam int RADIUS_W       = 16;
  localparam int MAX_POINTS_DEF = 64;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd320;

  // Divider status toward the core.
  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] quot_x;
    logic signed [COORD_W-1:0] quot_y;
  } gpc_div_res_t;

endpackage

[sv/gpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/gpc_div.sv]
// Two-lane iterative divider: signed sums by an unsigned count, truncating toward zero.
module gpc_div #(
  parameter int SUM_W = 22,
  parameter int CNT_W = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum_x,
  input  logic signed [SUM_W-1:0] sum_y,
  input  logic [CNT_W-1:0]        count,
  output gpc_pkg::gpc_div_res_t   res
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam int CW     = gpc_pkg::COORD_W;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt;
  logic [CNT_W-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  logic [CNT_W-1:0]  d_r, d_nxt;
  logic              negx_r, negx_nxt, negy_r, negy_nxt;
  logic [CNT_W:0]    shx, shy;
  logic [CW-1:0]     qx, qy;

  assign shx = {rx_r, ax_r[SUM_W-1]};
  assign shy = {ry_r, ay_r[SUM_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    ax_nxt   = ax_r;
    ay_nxt   = ay_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    d_nxt    = d_r;
    negx_nxt = negx_r;
    negy_nxt = negy_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      negx_nxt = sum_x[SUM_W-1];
      negy_nxt = sum_y[SUM_W-1];
      ax_nxt   = sum_x[SUM_W-1] ? (~sum_x + 1'b1) : sum_x;
      ay_nxt   = sum_y[SUM_W-1] ? (~sum_y + 1'b1) : sum_y;
      rx_nxt   = '0;
      ry_nxt   = '0;
      d_nxt    = count;
    end else if (busy_r) begin
      // one quotient bit per lane per cycle
      ax_nxt = {ax_r[SUM_W-2:0], 1'b0};
      ay_nxt = {ay_r[SUM_W-2:0], 1'b0};
      if (shx >= {1'b0, d_r}) begin
        rx_nxt    = CNT_W'(shx - {1'b0, d_r});
        ax_nxt[0] = 1'b1;
      end else begin
        rx_nxt = shx[CNT_W-1:0];
      end
      if (shy >= {1'b0, d_r}) begin
        ry_nxt    = CNT_W'(shy - {1'b0, d_r});
        ay_nxt[0] = 1'b1;
      end else begin
        ry_nxt = shy[CNT_W-1:0];
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    d_r    <= d_nxt;
    negx_r <= negx_nxt;
    negy_r <= negy_nxt;
  end

  assign qx = negx_r ? (~ax_r[CW-1:0] + 1'b1) : ax_r[CW-1:0];
  assign qy = negy_r ? (~ay_r[CW-1:0] + 1'b1) : ay_r[CW-1:0];

  assign res.done   = done_r;
  assign res.quot_x = qx;
  assign res.quot_y = qy;

endmodule

[sv/greedy_point_clustering_core.sv]
// Top level of the greedy leader clustering core.
//
//   channel   ports                                        transfer when
//   -------   ------------------------------------------   ----------------------
//   input     in_point_x, in_point_y, in_last_point        start && !busy
//   result    out_centroid_x/_y, out_last_cluster,          out_strobe (one cycle)
//             out_overflowed
//   config    cfg_we, cfg_wdata (cluster radius)           cfg_we
//
// Loading: one point per cycle, busy stays low until the last point.
// Clustering: per leader a seek and a leader read, then a scan over every later point
// and the centroid division; each already-taken entry costs a seek and a read; one
// closing seek at the end. Reset (synchronous, rst_n low) clears count, overflow and
// control. Taken flags sit beside each point in the RAM and are cleared as the point
// is loaded, so the RAM needs no clearing. Results cannot be stalled.
`include "greedy_point_clustering_core_macros.svh"
module greedy_point_clustering_core #(
  parameter int MAX_POINTS = gpc_pkg::MAX_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [gpc_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [gpc_pkg::COORD_W-1:0]   in_point_y,
  input  logic                                 in_last_point,
  output logic                                 out_strobe,
  output logic signed [gpc_pkg::COORD_W-1:0]   out_centroid_x,
  output logic signed [gpc_pkg::COORD_W-1:0]   out_centroid_y,
  output logic                                 out_last_cluster,
  output logic                                 out_overflowed,
  input  logic                                 cfg_we,
  input  logic [gpc_pkg::RADIUS_W-1:0]         cfg_wdata
);

  localparam int CW    = gpc_pkg::COORD_W;
  localparam int RW    = gpc_pkg::RADIUS_W;
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = CW + IDX_W;   // sum of up to MAX_POINTS coordinates
  localparam int DW    = CW + 1;       // coordinate difference
  localparam int SQ_W  = 2 * DW;       // its square
  localparam int D2_W  = SQ_W;         // sum of two squares (each below 2^33)
  localparam int TH_W  = 2 * RW;
  localparam int RAM_W = 2 * CW + 1;   // {taken, x, y}

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SEEK  = 3'd1;   // read next leader candidate
  localparam logic [2:0] S_LREAD = 3'd2;   // candidate data and taken flag return
  localparam logic [2:0] S_SCAN  = 3'd3;   // compare later points against leader
  localparam logic [2:0] S_DIV   = 3'd4;   // centroid division

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [RW-1:0]          radius_r;
  logic [TH_W-1:0]        thresh_r;
  logic [CNT_W-1:0]       lead_r, lead_nxt;
  logic [CNT_W-1:0]       k_r, k_nxt;
  logic signed [CW-1:0]   lx_r, lx_nxt, ly_r, ly_nxt;
  logic signed [SUM_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;

  // scan pipeline: RAM read -> difference -> squares -> compare/update
  logic                   rv_r, rv_nxt;
  logic [IDX_W-1:0]       ridx_r;
  logic                   va_r;
  logic [IDX_W-1:0]       aidx_r;
  logic                   atk_r;
  logic signed [CW-1:0]   ax_r, ay_r;
  logic signed [DW-1:0]   dx_r, dy_r;
  logic                   vb_r;
  logic [IDX_W-1:0]       bidx_r;
  logic                   btk_r;
  logic signed [CW-1:0]   bx_r, by_r;
  logic signed [SQ_W-1:0] sqx_r, sqy_r;
  logic [D2_W-1:0]        d2;
  logic                   hit;

  // pending result, sent once the next one or the end of the set is known
  logic                   pend_v_r, pend_v_nxt;
  logic signed [CW-1:0]   pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;

  logic                   ostb_r, ostb_nxt;
  logic signed [CW-1:0]   ox_r, ox_nxt, oy_r, oy_nxt;
  logic                   olast_r, olast_nxt;
  logic                   oovf_r, oovf_nxt;

  logic                   load_we;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [RAM_W-1:0]       ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [RAM_W-1:0]       ram_rdata;
  logic                   rd_taken;
  logic signed [CW-1:0]   rd_x, rd_y;
  logic                   div_start;
  gpc_pkg::gpc_div_res_t  div_res;
  logic                   issue;
  logic                   scan_done;

  assign busy     = (state_r != S_LOAD);
  assign rd_taken = ram_rdata[2*CW];
  assign rd_x     = ram_rdata[2*CW-1:CW];
  assign rd_y     = ram_rdata[CW-1:0];
  assign issue = (k_r < cnt_r);
  assign scan_done = !issue && !rv_r && !va_r && !vb_r;
  assign d2 = {1'b0, sqx_r[SQ_W-2:0]} + {1'b0, sqy_r[SQ_W-2:0]};
  // a later untaken point within reach joins the current leader
  assign hit = (state_r == S_SCAN) && vb_r && !btk_r && (d2 <= D2_W'(thresh_r));
  // loading writes the point with a clear flag; a join writes the flag back
  assign load_we   = (state_r == S_LOAD) && start && (cnt_r < CNT_W'(MAX_POINTS));
  assign ram_we    = load_we || hit;
  assign ram_waddr = (state_r == S_SCAN) ? bidx_r : cnt_r[IDX_W-1:0];
  assign ram_wdata = (state_r == S_SCAN) ? {1'b1, bx_r, by_r}
                                         : {1'b0, in_point_x, in_point_y};
  assign ram_raddr = (state_r == S_SEEK) ? lead_r[IDX_W-1:0] : k_r[IDX_W-1:0];
  assign div_start = (state_r == S_SCAN) && scan_done;

  gpc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gpc_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum_x (sx_r),
    .sum_y (sy_r),
    .count (n_r),
    .res   (div_res)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    lead_nxt   = lead_r;
    k_nxt      = k_r;
    lx_nxt     = lx_r;
    ly_nxt     = ly_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    n_nxt      = n_r;
    rv_nxt     = 1'b0;
    pend_v_nxt = pend_v_r;
    pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;
    ostb_nxt   = 1'b0;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    olast_nxt  = olast_r;
    oovf_nxt   = oovf_r;
    unique case (state_r)
      S_LOAD: begin
        if (start) begin
          if (cnt_r < CNT_W'(MAX_POINTS)) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_point) begin
            lead_nxt  = '0;
            state_nxt = S_SEEK;
          end
        end
      end
      S_SEEK: begin
        if (lead_r >= cnt_r) begin
          // end of set: flush the held result as the final one
          ostb_nxt   = pend_v_r;
          ox_nxt     = pend_x_r;
          oy_nxt     = pend_y_r;
          olast_nxt  = 1'b1;
          oovf_nxt   = ovf_r;
          pend_v_nxt = 1'b0;
          cnt_nxt    = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_LOAD;
        end else begin
          state_nxt = S_LREAD;
        end
      end
      S_LREAD: begin
        if (rd_taken) begin
          lead_nxt  = lead_r + 1'b1;
          state_nxt = S_SEEK;
        end else begin
          // a leader is never read again in this set, so its flag stays as is
          lx_nxt    = rd_x;
          ly_nxt    = rd_y;
          sx_nxt    = SUM_W'(rd_x);
          sy_nxt    = SUM_W'(rd_y);
          n_nxt     = CNT_W'(1);
          k_nxt     = lead_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rv_nxt = 1'b1;
          k_nxt  = k_r + 1'b1;
        end
        // flags written here lie below every later scan read and land before
        // the next seek, so no forwarding is needed
        if (hit) begin
          sx_nxt = sx_r + SUM_W'(bx_r);
          sy_nxt = sy_r + SUM_W'(by_r);
          n_nxt  = n_r + 1'b1;
        end
        if (scan_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          ostb_nxt   = pend_v_r;
          ox_nxt     = pend_x_r;
          oy_nxt     = pend_y_r;
          olast_nxt  = 1'b0;
          oovf_nxt   = ovf_r;
          pend_v_nxt = 1'b1;
          pend_x_nxt = div_res.quot_x;
          pend_y_nxt = div_res.quot_y;
          lead_nxt   = lead_r + 1'b1;
          state_nxt  = S_SEEK;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      radius_r <= gpc_pkg::RADIUS_RESET;
      thresh_r <= '0;
      rv_r     <= 1'b0;
      va_r     <= 1'b0;
      vb_r     <= 1'b0;
      pend_v_r <= 1'b0;
      ostb_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      thresh_r <= radius_r * radius_r;   // Q.8 merge threshold
      rv_r     <= rv_nxt;
      va_r     <= rv_r;
      vb_r     <= va_r;
      pend_v_r <= pend_v_nxt;
      ostb_r   <= ostb_nxt;
    end
    lead_r   <= lead_nxt;
    k_r      <= k_nxt;
    lx_r     <= lx_nxt;
    ly_r     <= ly_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    n_r      <= n_nxt;
    ridx_r   <= k_r[IDX_W-1:0];
    aidx_r   <= ridx_r;
    atk_r    <= rd_taken;
    ax_r     <= rd_x;
    ay_r     <= rd_y;
    dx_r     <= DW'(rd_x) - DW'(lx_r);
    dy_r     <= DW'(rd_y) - DW'(ly_r);
    bidx_r   <= aidx_r;
    btk_r    <= atk_r;
    bx_r     <= ax_r;
    by_r     <= ay_r;
    sqx_r    <= dx_r * dx_r;
    sqy_r    <= dy_r * dy_r;
    pend_x_r <= pend_x_nxt;
    pend_y_r <= pend_y_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    olast_r  <= olast_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign out_strobe       = ostb_r;
  assign out_centroid_x   = ox_r;
  assign out_centroid_y   = oy_r;
  assign out_last_cluster = olast_r;
  assign out_overflowed   = oovf_r;

  // final result of a set leaves the core idle with a cleared store
  `GPC_ASSERT_NOW(a_last_clears, clk, rst_n, out_strobe && out_last_cluster,
    (state_r == S_LOAD) && (cnt_r == '0) && !ovf_r)
  // a point offered to a full store sets the overflow flag
  `GPC_ASSERT_NEXT(a_full_overflow, clk, rst_n,
    start && !busy && (cnt_r == CNT_W'(MAX_POINTS)), ovf_r)
  // scan pipeline only carries entries while scanning
  `GPC_ASSERT_NOW(a_scan_pipe, clk, rst_n, rv_r || va_r || vb_r, state_r == S_SCAN)
  // divider finishes only while the core waits for it
  `GPC_ASSERT_NOW(a_div_state, clk, rst_n, div_res.done, state_r == S_DIV)

endmodule

[sim/tb_greedy_point_clustering_core.sv]
// Self-checking testbench for the greedy leader clustering core.
`timescale 1ns / 100ps

module tb_greedy_point_clustering_core;

  // Store depth of the instance below (default parameter).
  localparam int CAPACITY = gpc_pkg::MAX_POINTS_DEF;
  localparam int CW       = gpc_pkg::COORD_W;
  localparam int RW       = gpc_pkg::RADIUS_W;

  typedef logic signed [CW-1:0] coord_t;

  // One expected cluster result.
  typedef struct {
    coord_t cx;
    coord_t cy;
    logic   last;
    logic   ovf;
  } centroid_t;

  // ---------------------------------------------------------------------------
  // Centroid tracker: keeps its own copy of the point store, taken flags and
  // radius, clusters each closed set and queues the centroids the core owes us.
  // ---------------------------------------------------------------------------
  class centroid_tracker;
    logic [RW-1:0]       radius;
    int                  x_pts [CAPACITY];
    int                  y_pts [CAPACITY];
    bit                  taken [CAPACITY];
    int                  loaded;
    bit                  dropped;
    centroid_t           pending_centroids [$];

    int mismatch_count;
    int sets_closed;
    int overflow_sets;
    int points_seen;
    int centroids_checked;
    int max_clusters;

    function new();
      radius  = gpc_pkg::RADIUS_RESET;
      loaded  = 0;
      dropped = 1'b0;
    endfunction

    // Called on every accepted point transfer.
    function void note_point(coord_t x, coord_t y, logic last);
      points_seen++;
      if (loaded < CAPACITY) begin
        x_pts[loaded] = int'(x);
        y_pts[loaded] = int'(y);
        loaded++;
      end else begin
        dropped = 1'b1;   // full store: point is lost, set gets flagged
      end
      if (last)
        cluster_set();
    endfunction

    // Greedy pass over the stored set, leaders in load order.
    function void cluster_set();
      longint    thresh;
      longint    sx;
      longint    sy;
      longint    n;
      longint    dx;
      longint    dy;
      longint    mean_x;
      longint    mean_y;
      centroid_t c;
      centroid_t found [$];
      thresh = longint'(radius) * longint'(radius);   // Q.8, exact
      for (int lead = 0; lead < loaded; lead++) begin
        if (taken[lead])
          continue;
        taken[lead] = 1'b1;
        sx = longint'(x_pts[lead]);
        sy = longint'(y_pts[lead]);
        n  = 1;
        for (int k = lead + 1; k < loaded; k++) begin
          if (taken[k])
            continue;
          dx = longint'(x_pts[k]) - longint'(x_pts[lead]);
          dy = longint'(y_pts[k]) - longint'(y_pts[lead]);
          if (dx * dx + dy * dy <= thresh) begin
            taken[k] = 1'b1;
            sx += longint'(x_pts[k]);
            sy += longint'(y_pts[k]);
            n++;
          end
        end
        // integer division truncates toward zero, as the core does
        mean_x = sx / n;
        mean_y = sy / n;
        c.cx   = mean_x[CW-1:0];
        c.cy   = mean_y[CW-1:0];
        c.last = 1'b0;
        c.ovf  = dropped;
        found.insert(found.size(), c);
      end
      if (found.size() > 0) begin
        c = found.pop_back();
        c.last = 1'b1;
        found.insert(found.size(), c);
      end
      foreach (found[i])
        pending_centroids.insert(pending_centroids.size(), found[i]);
      sets_closed++;
      if (dropped)
        overflow_sets++;
      if (found.size() > max_clusters)
        max_clusters = found.size();
      // end of set: flags, count and overflow start over
      taken   = '{default: 1'b0};
      loaded  = 0;
      dropped = 1'b0;
    endfunction

    task report(string what);
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Called on every result strobe.
    task check_centroid(coord_t cx, coord_t cy, logic last, logic ovf);
      centroid_t want;
      if (pending_centroids.size() == 0) begin
        report($sformatf("unexpected centroid (%0d, %0d) last=%0b ovf=%0b",
                         cx, cy, last, ovf));
        return;
      end
      want = pending_centroids.pop_front();
      centroids_checked++;
      if (cx !== want.cx)
        report($sformatf("centroid %0d x: got %0d, want %0d", centroids_checked, cx, want.cx));
      if (cy !== want.cy)
        report($sformatf("centroid %0d y: got %0d, want %0d", centroids_checked, cy, want.cy));
      if (last !== want.last)
        report($sformatf("centroid %0d last_cluster: got %0b, want %0b",
                         centroids_checked, last, want.last));
      if (ovf !== want.ovf)
        report($sformatf("centroid %0d overflowed: got %0b, want %0b",
                         centroids_checked, ovf, want.ovf));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                clk;
  logic                rst_n            = 1'b0;
  logic                start            = 1'b0;
  logic                busy;
  coord_t              in_point_x       = '0;
  coord_t              in_point_y       = '0;
  logic                in_last_point    = 1'b0;
  logic                out_strobe;
  coord_t              out_centroid_x;
  coord_t              out_centroid_y;
  logic                out_last_cluster;
  logic                out_overflowed;
  logic                cfg_we           = 1'b0;
  logic [RW-1:0]       cfg_wdata        = '0;

  centroid_tracker sb;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  greedy_point_clustering_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_last_point    (in_last_point),
    .out_strobe       (out_strobe),
    .out_centroid_x   (out_centroid_x),
    .out_centroid_y   (out_centroid_y),
    .out_last_cluster (out_last_cluster),
    .out_overflowed   (out_overflowed),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  // Result monitor. Outputs are read right after the edge, i.e. the values
  // that were on the ports during the cycle that this edge closes.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1)
      sb.check_centroid(out_centroid_x, out_centroid_y, out_last_cluster, out_overflowed);
  end

  // Run limit: far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("** greedy_point_clustering_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered right after a rising edge.
  // ---------------------------------------------------------------------------

  // One point transfer. start stays high after the transfer so that a
  // back-to-back point needs no second assignment in the same step; whoever
  // pauses lowers it.
  task send_point(input coord_t x, input coord_t y, input logic last, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_point_x    <= x;
    in_point_y    <= y;
    in_last_point <= last;
    do @(posedge clk); while (busy !== 1'b0);   // transfer at start && !busy
    sb.note_point(x, y, last);
  endtask

  // Wait until every owed centroid is in, then let the closing cycle of the
  // core pass and make sure it is idle again.
  task drain();
    start <= 1'b0;
    while (sb.pending_centroids.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy !== 1'b0)
      @(posedge clk);
  endtask

  // Radius write, only while the core is idle.
  task write_radius(input logic [RW-1:0] r);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.radius = r;
  endtask

  function automatic coord_t sat16(int v);
    if (v > 32767)
      return coord_t'(32767);
    if (v < -32768)
      return coord_t'(-32768);
    return v[CW-1:0];
  endfunction

  // One random set. Most points scatter around a few centers at distances
  // near the radius, so joins and misses both occur; some points are repeats
  // of the previous one and some are anywhere in the plane.
  task send_set(input int size, input int idle_pct);
    int     span;
    int     ncent;
    int     pick;
    int     r;
    int     cen_x [4];
    int     cen_y [4];
    coord_t px;
    coord_t py;
    coord_t prev_x;
    coord_t prev_y;
    span  = int'(sb.radius) + int'(sb.radius) / 2 + 1;
    ncent = $urandom_range(1, 4);
    for (int c = 0; c < 4; c++) begin
      cen_x[c] = int'($urandom_range(0, 65535)) - 32768;
      cen_y[c] = int'($urandom_range(0, 65535)) - 32768;
    end
    prev_x = '0;
    prev_y = '0;
    for (int i = 0; i < size; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        px = coord_t'($urandom);
        py = coord_t'($urandom);
      end else if (r < 25 && i > 0) begin
        px = prev_x;
        py = prev_y;
      end else begin
        pick = $urandom_range(0, ncent - 1);
        px = sat16(cen_x[pick] + int'($urandom_range(0, 2 * span)) - span);
        py = sat16(cen_y[pick] + int'($urandom_range(0, 2 * span)) - span);
      end
      send_point(px, py, i == size - 1, idle_pct);
      prev_x = px;
      prev_y = py;
    end
  endtask

  // One random phase: new radius, optional big set first, then mostly small
  // sets. Now and then the sender holds until all centroids are back.
  task run_phase(input int idle_pct, input logic [RW-1:0] radius,
                 input int big_set, input int budget);
    int sent;
    int size;
    int r;
    write_radius(radius);
    sent = 0;
    if (big_set > 0) begin
      send_set(big_set, idle_pct);
      sent = big_set;
    end
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        size = $urandom_range(1, 8);
      else if (r < 95)
        size = $urandom_range(9, 20);
      else
        size = $urandom_range(21, 40);
      send_set(size, idle_pct);
      sent += size;
      if ($urandom_range(0, 9) == 0)
        drain();
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset radius (20.0). Single point at the top corner.
    send_point(coord_t'(32767), coord_t'(32767), 1'b1, 0);
    // Four corners: every one its own cluster.
    send_point(coord_t'(-32768), coord_t'(-32768), 1'b0, 0);
    send_point(coord_t'(32767), coord_t'(32767), 1'b0, 0);
    send_point(coord_t'(-32768), coord_t'(32767), 1'b0, 0);
    send_point(coord_t'(32767), coord_t'(-32768), 1'b1, 0);
    // Distance exactly at the radius joins, one step past does not; a point
    // within reach of a member but not of the leader starts its own cluster;
    // the first centroid y is -5/4, which must truncate to -1.
    send_point(coord_t'(0), coord_t'(0), 1'b0, 0);
    send_point(coord_t'(320), coord_t'(0), 1'b0, 0);
    send_point(coord_t'(0), coord_t'(321), 1'b0, 0);
    send_point(coord_t'(600), coord_t'(0), 1'b0, 0);
    send_point(coord_t'(-5), coord_t'(-3), 1'b0, 0);
    send_point(coord_t'(-4), coord_t'(-2), 1'b1, 0);
    drain();

    // Zero radius: only coincident points merge.
    write_radius('0);
    send_point(coord_t'(100), coord_t'(-100), 1'b0, 0);
    send_point(coord_t'(100), coord_t'(-100), 1'b0, 0);
    send_point(coord_t'(101), coord_t'(-100), 1'b0, 0);
    send_point(coord_t'(-7), coord_t'(-9), 1'b0, 0);
    send_point(coord_t'(-7), coord_t'(-9), 1'b1, 0);
    drain();

    // Largest radius: a full-height gap sits exactly on the threshold, the
    // opposite corner is out of reach.
    write_radius('1);
    send_point(coord_t'(-32768), coord_t'(-32768), 1'b0, 0);
    send_point(coord_t'(32767), coord_t'(32767), 1'b0, 0);
    send_point(coord_t'(-32768), coord_t'(32767), 1'b0, 0);
    send_point(coord_t'(1), coord_t'(-3), 1'b0, 0);
    send_point(coord_t'(-2), coord_t'(0), 1'b1, 0);
    drain();

    // Random phases: back to back; sender mostly idle; back to back with a
    // full store; light idling at any radius. The big sets hit the capacity
    // edge: closing on a dropped point, on the first dropped point, and on
    // the point that just fills the store.
    run_phase(0,  RW'($urandom_range(16, 2048)), CAPACITY + 3, 112);
    run_phase(87, RW'($urandom_range(16, 2048)), CAPACITY + 1, 112);
    run_phase(0,  RW'($urandom_range(16, 2048)), CAPACITY,     112);
    run_phase(21, RW'($urandom_range(0, 65535)), 0,            112);

    // Tail: catch any stray strobe after the last set.
    repeat (100) @(posedge clk);
    if (sb.pending_centroids.size() != 0)
      sb.report($sformatf("%0d centroids never arrived", sb.pending_centroids.size()));

    $display("Run covered %0d points in %0d sets (%0d over capacity), up to %0d clusters per set.",
             sb.points_seen, sb.sets_closed, sb.overflow_sets, sb.max_clusters);
    $display("Checked %0d centroids at radii 0, 320, 65535 and four random ones; %0d mismatches.",
             sb.centroids_checked, sb.mismatch_count);
    if (sb.mismatch_count == 0) begin
      $display("** greedy_point_clustering_core: PASSED **");
    end else begin
      $display("** greedy_point_clustering_core: FAILED **");
    end
    $finish;
  end

endmodule
